>>> rtl/wrcr_pkg.sv
// ----------------------------------------------------------------------------
// wrcr_pkg
// Shared types and constants for the window range clamped rescale unit:
// configuration register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package wrcr_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int NORM_BITS      = 24;
    localparam int MARGIN_BITS    = 16;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLAMP_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS          = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORM_SCALE      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN_FRACTION = 2'd3;

    // reset values: clamp on, no bypass, 1/16384 scale, margin ~0.1
    localparam logic                   RST_CLAMP_ENABLE    = 1'b1;
    localparam logic                   RST_BYPASS          = 1'b0;
    localparam logic [NORM_BITS-1:0]   RST_NORM_SCALE      = 24'd1024;
    localparam logic [MARGIN_BITS-1:0] RST_MARGIN_FRACTION = 16'd6554;

    typedef struct packed {
        logic                   clamp_enable;
        logic                   bypass;
        logic [NORM_BITS-1:0]   norm_scale;
        logic [MARGIN_BITS-1:0] margin_fraction;
    } cfg_t;

endpackage

>>> rtl/wrcr_cell.sv
// ----------------------------------------------------------------------------
// wrcr_cell
// One column slot of the history chain: holds the vertical min/max of a
// column plus its centre and filtered samples, and passes them on to the
// next slot whenever a new column item is taken.
// ----------------------------------------------------------------------------
module wrcr_cell #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FILTERED_BITS = 32
) (
    input  logic                            clk,
    input  logic                            shift,
    input  logic signed [SAMPLE_BITS-1:0]   min_in,
    input  logic signed [SAMPLE_BITS-1:0]   max_in,
    input  logic signed [SAMPLE_BITS-1:0]   centre_in,
    input  logic signed [FILTERED_BITS-1:0] filt_in,
    output logic signed [SAMPLE_BITS-1:0]   min_out,
    output logic signed [SAMPLE_BITS-1:0]   max_out,
    output logic signed [SAMPLE_BITS-1:0]   centre_out,
    output logic signed [FILTERED_BITS-1:0] filt_out
);

    logic signed [SAMPLE_BITS-1:0]   min_reg;
    logic signed [SAMPLE_BITS-1:0]   max_reg;
    logic signed [SAMPLE_BITS-1:0]   centre_reg;
    logic signed [FILTERED_BITS-1:0] filt_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            min_reg    <= min_in;
            max_reg    <= max_in;
            centre_reg <= centre_in;
            filt_reg   <= filt_in;
        end
    end

    assign min_out    = min_reg;
    assign max_out    = max_reg;
    assign centre_out = centre_reg;
    assign filt_out   = filt_reg;

endmodule

>>> rtl/wrcr_pipe.sv
// ----------------------------------------------------------------------------
// wrcr_pipe
// Rescale and clamp pipeline: scale multiply and margin multiply, window
// bounds, clamp, saturation and the output register. Each stage moves when
// the stage after it is empty or moving.
// ----------------------------------------------------------------------------
module wrcr_pipe #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FILTERED_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wrcr_pkg::cfg_t                  cfg,
    input  logic                            s1_valid,
    output logic                            s1_free,
    input  logic signed [SAMPLE_BITS-1:0]   win_min,
    input  logic signed [SAMPLE_BITS-1:0]   win_max,
    input  logic signed [SAMPLE_BITS-1:0]   win_centre,
    input  logic signed [FILTERED_BITS-1:0] win_filt,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic signed [SAMPLE_BITS-1:0]   result_value,
    output logic                            was_limited
);
    import wrcr_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int F  = FILTERED_BITS;
    localparam int PW = F + NORM_BITS + 1;       // scale product
    localparam int VW = F + 1;                   // scaled value
    localparam int DW = W + 1;                   // window range
    localparam int MW = DW + MARGIN_BITS;        // margin product
    localparam int BW = W + 2;                   // widened bounds
    localparam int CW = (VW > BW) ? VW : BW;     // clamp compare width

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (NORM_BITS - 1);
    localparam logic signed [CW-1:0] SAT_MAX = (CW'(1) << (W - 1)) - CW'(1);
    localparam logic signed [CW-1:0] SAT_MIN = -(CW'(1) << (W - 1));

    logic en2, en3, en4, en5, en_out;

    // stage 2: window bounds and delayed samples
    logic                  s2_valid_reg;
    logic signed [W-1:0]   s2_min_reg, s2_max_reg, s2_centre_reg;
    logic signed [F-1:0]   s2_filt_reg;

    // stage 3: products
    logic                  s3_valid_reg;
    logic signed [PW-1:0]  s3_prod_reg;
    logic [MW-1:0]         s3_mprod_reg;
    logic signed [W-1:0]   s3_min_reg, s3_max_reg, s3_centre_reg;

    // stage 4: scaled value and widened bounds
    logic                  s4_valid_reg;
    logic signed [VW-1:0]  s4_v_reg;
    logic signed [BW-1:0]  s4_lo_reg, s4_hi_reg;
    logic signed [W-1:0]   s4_centre_reg;

    // stage 5: clamped value
    logic                  s5_valid_reg;
    logic signed [VW-1:0]  s5_v_reg;
    logic signed [CW-1:0]  s5_clamp_reg;
    logic signed [W-1:0]   s5_centre_reg;

    logic                  out_valid_reg;
    logic signed [W-1:0]   result_reg;
    logic                  limited_reg;

    logic signed [PW-1:0]  prod_c;
    logic [DW-1:0]         dev_c;
    logic [MW-1:0]         mprod_c;
    logic signed [PW-1:0]  rnd_c;
    logic [DW-1:0]         margin_c;
    logic signed [CW-1:0]  v_ext_c, lo_ext_c, hi_ext_c, clamp_c;
    logic signed [CW-1:0]  sat_c;
    logic signed [W-1:0]   result_next;
    logic                  limited_next;

    assign en_out  = !out_valid_reg || !out_stall;
    assign en5     = !s5_valid_reg || en_out;
    assign en4     = !s4_valid_reg || en5;
    assign en3     = !s3_valid_reg || en4;
    assign en2     = !s2_valid_reg || en3;
    assign s1_free = !s1_valid || en2;

    always_comb
    begin
        prod_c   = PW'(s2_filt_reg) * signed'(PW'(cfg.norm_scale));
        dev_c    = DW'(DW'(s2_max_reg) - DW'(s2_min_reg));
        mprod_c  = MW'(dev_c) * MW'(cfg.margin_fraction);
        rnd_c    = s3_prod_reg + ROUND_HALF;
        margin_c = s3_mprod_reg[MW-1:MARGIN_BITS];
        v_ext_c  = CW'(s4_v_reg);
        lo_ext_c = CW'(s4_lo_reg);
        hi_ext_c = CW'(s4_hi_reg);
        clamp_c  = v_ext_c;
        if (cfg.clamp_enable)
        begin
            if (clamp_c > hi_ext_c)
            begin
                clamp_c = hi_ext_c;
            end
            if (clamp_c < lo_ext_c)
            begin
                clamp_c = lo_ext_c;
            end
        end
        sat_c = s5_clamp_reg;
        if (sat_c > SAT_MAX)
        begin
            sat_c = SAT_MAX;
        end
        if (sat_c < SAT_MIN)
        begin
            sat_c = SAT_MIN;
        end
        if (cfg.bypass)
        begin
            result_next  = s5_centre_reg;
            limited_next = 1'b0;
        end
        else
        begin
            result_next  = sat_c[W-1:0];
            limited_next = (sat_c != CW'(s5_v_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_min_reg    <= win_min;
            s2_max_reg    <= win_max;
            s2_centre_reg <= win_centre;
            s2_filt_reg   <= win_filt;
        end
        if (en3)
        begin
            s3_prod_reg   <= prod_c;
            s3_mprod_reg  <= mprod_c;
            s3_min_reg    <= s2_min_reg;
            s3_max_reg    <= s2_max_reg;
            s3_centre_reg <= s2_centre_reg;
        end
        if (en4)
        begin
            // round half up, drop the Q0.24 fraction
            s4_v_reg      <= rnd_c[PW-1:NORM_BITS];
            s4_lo_reg     <= BW'(s3_min_reg) - signed'(BW'(margin_c));
            s4_hi_reg     <= BW'(s3_max_reg) + signed'(BW'(margin_c));
            s4_centre_reg <= s3_centre_reg;
        end
        if (en5)
        begin
            s5_v_reg      <= s4_v_reg;
            s5_clamp_reg  <= clamp_c;
            s5_centre_reg <= s4_centre_reg;
        end
        if (en_out)
        begin
            result_reg  <= result_next;
            limited_reg <= limited_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign was_limited  = limited_reg;

endmodule

>>> rtl/window_range_clamped_rescale_unit.sv
// ----------------------------------------------------------------------------
// window_range_clamped_rescale_unit
// Streams pixel columns through a chain of history cells and rescales the
// filtered sample of the column WINDOW_RADIUS back, clamped to the widened
// min/max range of the surrounding window.
// ----------------------------------------------------------------------------
// One column item is taken per clock while in_stall is low. The first
// 2*WINDOW_RADIUS columns of a row give no result; every later column gives
// one result, for the column WINDOW_RADIUS back, once the column has passed
// the cell chain for the window min/max, the window register, then the
// multiply, bounds, clamp and saturate/output registers. in_stall rises only
// when out_stall holds the output and the five pipeline stages behind it are all full.
module window_range_clamped_rescale_unit #(
    parameter int WINDOW_RADIUS = 2,
    parameter int SAMPLE_BITS   = 24,
    parameter int FILTERED_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wrcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wrcr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        org_top2,
    input  logic signed [SAMPLE_BITS-1:0]        org_top1,
    input  logic signed [SAMPLE_BITS-1:0]        org_mid,
    input  logic signed [SAMPLE_BITS-1:0]        org_bot1,
    input  logic signed [SAMPLE_BITS-1:0]        org_bot2,
    input  logic signed [FILTERED_BITS-1:0]      filtered_raw,
    input  logic                                 row_start,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        result_value,
    output logic                                 was_limited
);
    import wrcr_pkg::*;

    localparam int HIST     = 2 * WINDOW_RADIUS;
    localparam int NCELLS   = HIST + 1;
    localparam int SEEN_W   = $clog2(HIST + 1);
    localparam int NROWS    = 5;

    cfg_t cfg_reg;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_eff;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_free;
    logic              accept;
    logic              produce;

    logic signed [SAMPLE_BITS-1:0] col [NROWS];
    logic signed [SAMPLE_BITS-1:0] col_min, col_max;

    logic signed [SAMPLE_BITS-1:0]   chain_min    [NCELLS+1];
    logic signed [SAMPLE_BITS-1:0]   chain_max    [NCELLS+1];
    logic signed [SAMPLE_BITS-1:0]   chain_centre [NCELLS+1];
    logic signed [FILTERED_BITS-1:0] chain_filt   [NCELLS+1];

    logic signed [SAMPLE_BITS-1:0] win_min, win_max;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_enable    <= RST_CLAMP_ENABLE;
            cfg_reg.bypass          <= RST_BYPASS;
            cfg_reg.norm_scale      <= RST_NORM_SCALE;
            cfg_reg.margin_fraction <= RST_MARGIN_FRACTION;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLAMP_ENABLE:    cfg_reg.clamp_enable    <= cfg_data[0];
                REG_BYPASS:          cfg_reg.bypass          <= cfg_data[0];
                REG_NORM_SCALE:      cfg_reg.norm_scale      <= cfg_data[NORM_BITS-1:0];
                REG_MARGIN_FRACTION: cfg_reg.margin_fraction <= cfg_data[MARGIN_BITS-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign accept   = in_valid && s1_free;
    assign in_stall = !s1_free;

    // vertical min/max of the incoming column
    always_comb
    begin
        col[0] = org_top2;
        col[1] = org_top1;
        col[2] = org_mid;
        col[3] = org_bot1;
        col[4] = org_bot2;
        col_min = col[0];
        col_max = col[0];
        for (int i = 1; i < NROWS; i++)
        begin
            if (col[i] < col_min)
            begin
                col_min = col[i];
            end
            if (col[i] > col_max)
            begin
                col_max = col[i];
            end
        end
    end

    // column count within the row, saturating at a full history
    always_comb
    begin
        seen_eff  = row_start ? '0 : seen_reg;
        produce   = (seen_eff >= SEEN_W'(HIST));
        seen_next = seen_reg;
        if (accept)
        begin
            seen_next = produce ? seen_eff : seen_eff + SEEN_W'(1);
        end
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = produce;
        end
        else if (s1_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign chain_min[0]    = col_min;
    assign chain_max[0]    = col_max;
    assign chain_centre[0] = org_mid;
    assign chain_filt[0]   = filtered_raw;

    // cell k holds the column taken k items ago; the chain spans the window
    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        wrcr_cell #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .FILTERED_BITS (FILTERED_BITS)
        ) u_cell (
            .clk        (clk),
            .shift      (accept),
            .min_in     (chain_min[k]),
            .max_in     (chain_max[k]),
            .centre_in  (chain_centre[k]),
            .filt_in    (chain_filt[k]),
            .min_out    (chain_min[k+1]),
            .max_out    (chain_max[k+1]),
            .centre_out (chain_centre[k+1]),
            .filt_out   (chain_filt[k+1])
        );
    end

    always_comb
    begin
        win_min = chain_min[1];
        win_max = chain_max[1];
        for (int k = 2; k <= NCELLS; k++)
        begin
            if (chain_min[k] < win_min)
            begin
                win_min = chain_min[k];
            end
            if (chain_max[k] > win_max)
            begin
                win_max = chain_max[k];
            end
        end
    end

    wrcr_pipe #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FILTERED_BITS (FILTERED_BITS)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .s1_valid     (s1_valid_reg),
        .s1_free      (s1_free),
        .win_min      (win_min),
        .win_max      (win_max),
        .win_centre   (chain_centre[WINDOW_RADIUS+1]),
        .win_filt     (chain_filt[WINDOW_RADIUS+1]),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .was_limited  (was_limited)
    );

endmodule

>>> rtl/wrcr_checker.sv
// ----------------------------------------------------------------------------
// wrcr_checker
// Port-level checks for the window range clamped rescale unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module wrcr_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_we,
    input logic [wrcr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input logic [wrcr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [SAMPLE_BITS-1:0]        result_value,
    input logic                                 was_limited
);
    import wrcr_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic clamp_en_reg;
    logic bypass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_en_reg <= RST_CLAMP_ENABLE;
            bypass_reg   <= RST_BYPASS;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CLAMP_ENABLE)
            begin
                clamp_en_reg <= cfg_data[0];
            end
            if (cfg_index == REG_BYPASS)
            begin
                bypass_reg <= cfg_data[0];
            end
        end
    end

    // an empty output register never holds back the input side
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    // bypassed items are never flagged
    a_bypass_unlimited: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bypass_reg |-> !was_limited)
        else $error("was_limited set in bypass");

    // with clamping off only saturation can flag an item
    a_noclamp_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bypass_reg && !clamp_en_reg && was_limited
        |-> (result_value == SAT_MAX) || (result_value == SAT_MIN))
        else $error("flagged item not saturated with clamp off");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
        && $stable(was_limited))
        else $error("stalled output item changed");

endmodule

bind window_range_clamped_rescale_unit wrcr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wrcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .was_limited  (was_limited)
);
